// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the channel time meter.
// Each macro expands to nothing when NO_ASSERTIONS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Property checked at every rising edge of clk outside reset
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, prop, msg)
`define ASSERT_IMPL(lbl, ante, cons, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// File: hw/rtl/pctm_pkg.sv
// Types, constants and helper functions of the prepaid channel time meter.
// No dependencies; used by the interfaces and the top level.
package pctm_pkg;

    // Channel count and field widths
    localparam int NUM_CHANNELS = 4;
    localparam int CH_W         = 2;
    localparam int CMD_W        = 3;
    localparam int MONEY_W      = 16;
    localparam int TIME_W       = 14;
    localparam int DISP_W       = 10;
    localparam int MODE_W       = 2;
    localparam int REFUND_W     = 16;
    localparam int RATE_W       = 16;

    // Arithmetic widths: money*rate*10 and the divisor rate*10
    localparam int PROD_W   = 32;
    localparam int NUM_W    = 36;
    localparam int DEN_W    = 20;
    localparam int REM_W    = DEN_W + 1;
    localparam int DIV_CNT_W = 6;

    localparam logic [TIME_W-1:0]   TIME_MAX  = TIME_W'(9999);
    localparam logic [TIME_W-1:0]   TICK_STEP = TIME_W'(10);
    localparam logic [REFUND_W-1:0] REFUND_MAX = '1;

    // Commands
    localparam logic [CMD_W-1:0] CMD_CREDIT    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_REFUND    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_MINUTE    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DISPLAY   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR     = 3'd4;
    localparam logic [CMD_W-1:0] CMD_CLEAR_ALL = 3'd5;

    // Display modes
    localparam logic [MODE_W-1:0] MODE_VALUE  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BLANK  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MARKER = 2'd2;

    // Configuration register indexes and address width
    localparam int PADDR_W = 4;
    localparam logic [1:0] REG_TIME_RATE    = 2'd0;
    localparam logic [1:0] REG_MONEY_RATE   = 2'd1;
    localparam logic [1:0] REG_FACTORY_MODE = 2'd2;

    // One result
    typedef struct packed {
        logic [CH_W-1:0]     out_channel;
        logic [TIME_W-1:0]   remaining_time;
        logic [DISP_W-1:0]   display_value;
        logic [MODE_W-1:0]   display_mode;
        logic                relay_on;
        logic [REFUND_W-1:0] refund_amount;
        logic                last;
    } result_t;

    // time / 10 by reciprocal multiply, exact for every time up to 9999
    function automatic logic [DISP_W-1:0] div10(input logic [TIME_W-1:0] t);
        logic [29:0] p;
        p = 30'(t) * 30'd52429;
        return p[28:19];
    endfunction

endpackage

// File: hw/rtl/pctm_if.sv
// Valid/ready channels of the channel time meter: request in, result out.
// Depends on pctm_pkg for the field widths.
interface pctm_req_if;
    logic                             valid;
    logic                             ready;
    logic [pctm_pkg::CMD_W-1:0]       command;
    logic [pctm_pkg::CH_W-1:0]        channel;
    logic [pctm_pkg::MONEY_W-1:0]     money_amount;

    modport source (output valid, command, channel, money_amount, input ready);
    modport sink   (input valid, command, channel, money_amount, output ready);
endinterface

interface pctm_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [pctm_pkg::CH_W-1:0]        out_channel;
    logic [pctm_pkg::TIME_W-1:0]      remaining_time;
    logic [pctm_pkg::DISP_W-1:0]      display_value;
    logic [pctm_pkg::MODE_W-1:0]      display_mode;
    logic                             relay_on;
    logic [pctm_pkg::REFUND_W-1:0]    refund_amount;
    logic                             last;

    modport source (output valid, out_channel, remaining_time, display_value, display_mode,
                    relay_on, refund_amount, last, input ready);
    modport sink   (input valid, out_channel, remaining_time, display_value, display_mode,
                    relay_on, refund_amount, last, output ready);
endinterface

// File: hw/rtl/prepaid_channel_time_meter_top.sv
// Prepaid channel time meter: per-channel time store, shared multiply/divide sequencer.
// Depends on pctm_pkg, pctm_if.sv and assert_macros.svh.
//
// Usage:
//   req  : one request per command (credit, refund query, minute tick, display tick,
//          clear channel, clear all). Accepted when valid and ready are high.
//   rsp  : result stream; one result for credit, refund and clear channel, one per
//          channel (channel 0 first, last set on the final one) for minute tick,
//          clear all and display tick. Display tick gives nothing in factory mode.
//   APB  : time_rate at 0x0, money_rate at 0x4, factory_mode at 0x8; pready tied high.
// Sequence:
//   credit and refund query: a multiply state, a times-ten state, 36 restoring
//   divide steps and a finish state that loads the output register; the next
//   request is taken only once the sequencer is back in idle.
//   Walk commands: each channel in turn, channel 0 first, as the output register frees.
//   Clear channel: finish state only. Unused commands and ignored requests go straight back to idle.
//   ready is high only while the sequencer is idle; one request at a time.
// Reset: all channel times and the flash phase clear, rates return to 1, factory
//   mode to 0; the block is ready in the first cycle after reset.
// Stall: results wait in an output register; the sequencer holds while that
//   register is full and not taken, and a new request is still taken when idle.
`include "assert_macros.svh"

module prepaid_channel_time_meter_top (
    input  logic                               clk,
    input  logic                               rst_n,
    pctm_req_if.sink                           req,
    pctm_rsp_if.source                         rsp,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [pctm_pkg::PADDR_W-1:0]       paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    // Sequencer state codes
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL1 = 3'd1;
    localparam logic [2:0] S_MUL2 = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;
    localparam logic [2:0] S_WALK = 3'd5;

    localparam logic [pctm_pkg::DIV_CNT_W-1:0] DIV_LAST =
        pctm_pkg::DIV_CNT_W'(pctm_pkg::NUM_W - 1);
    localparam logic [pctm_pkg::CH_W-1:0] CH_LAST =
        pctm_pkg::CH_W'(pctm_pkg::NUM_CHANNELS - 1);

    // Configuration
    logic [pctm_pkg::RATE_W-1:0] time_rate_reg;
    logic [pctm_pkg::RATE_W-1:0] money_rate_reg;
    logic                        factory_mode_reg;

    // Channel store and flash phase
    logic [pctm_pkg::TIME_W-1:0] channel_time_reg [pctm_pkg::NUM_CHANNELS];
    logic                        flash_phase_reg;

    // Sequencer
    logic [2:0]                      state_reg, state_next;
    logic [pctm_pkg::CMD_W-1:0]      cmd_reg;
    logic [pctm_pkg::CH_W-1:0]       ch_reg;
    logic [pctm_pkg::MONEY_W-1:0]    money_reg;
    logic [pctm_pkg::CH_W-1:0]       walk_reg;
    logic [pctm_pkg::DIV_CNT_W-1:0]  div_cnt_reg;
    logic [pctm_pkg::NUM_W-1:0]      num_reg;
    logic [pctm_pkg::DEN_W-1:0]      den_reg;
    logic [pctm_pkg::REM_W-1:0]      rem_reg;

    // Output register
    logic                  out_valid_reg;
    pctm_pkg::result_t     out_reg;

    // Datapath
    logic                          req_fire;
    logic                          slot_free;
    logic                          ch_ok;
    logic [pctm_pkg::CH_W-1:0]     rd_idx;
    logic [pctm_pkg::TIME_W-1:0]   rd_time;
    logic [pctm_pkg::RATE_W-1:0]   mul_a;
    logic [pctm_pkg::RATE_W-1:0]   mul_b;
    logic [pctm_pkg::PROD_W-1:0]   mul_p;
    logic [pctm_pkg::PROD_W-1:0]   x10_in;
    logic [pctm_pkg::NUM_W-1:0]    x10_out;
    logic [pctm_pkg::REM_W-1:0]    rem_shift;
    logic                          q_bit;
    logic [pctm_pkg::NUM_W:0]      credit_sum;
    logic [pctm_pkg::TIME_W-1:0]   credit_time;
    logic [pctm_pkg::REFUND_W-1:0] refund_val;
    logic [pctm_pkg::TIME_W-1:0]   walk_time;
    logic [pctm_pkg::MODE_W-1:0]   walk_mode;
    logic                          cfg_wr;

    assign req_fire  = req.valid && req.ready;
    assign slot_free = !out_valid_reg || rsp.ready;
    assign ch_ok     = int'(req.channel) < pctm_pkg::NUM_CHANNELS;

    // Single read port of the channel store
    assign rd_idx  = (state_reg == S_WALK) ? walk_reg : ch_reg;
    assign rd_time = channel_time_reg[rd_idx];

    // Shared multiplier: money*time_rate for credit, time*money_rate for refund
    assign mul_a = (cmd_reg == pctm_pkg::CMD_CREDIT) ? money_reg
                                                     : pctm_pkg::RATE_W'(rd_time);
    assign mul_b = (cmd_reg == pctm_pkg::CMD_CREDIT) ? time_rate_reg : money_rate_reg;
    assign mul_p = pctm_pkg::PROD_W'(mul_a) * pctm_pkg::PROD_W'(mul_b);

    // Shared times-ten adder: numerator for credit, divisor for refund
    assign x10_in  = (cmd_reg == pctm_pkg::CMD_CREDIT) ? num_reg[pctm_pkg::PROD_W-1:0]
                                                       : pctm_pkg::PROD_W'(time_rate_reg);
    assign x10_out = pctm_pkg::NUM_W'({x10_in, 3'b000})
                     + pctm_pkg::NUM_W'({x10_in, 1'b0});

    // Restoring divide step; a zero divisor yields an all-ones quotient
    assign rem_shift = {rem_reg[pctm_pkg::REM_W-2:0], num_reg[pctm_pkg::NUM_W-1]};
    assign q_bit     = rem_shift >= pctm_pkg::REM_W'(den_reg);

    // Finish: saturate credit sum and refund
    assign credit_sum  = (pctm_pkg::NUM_W+1)'(rd_time) + (pctm_pkg::NUM_W+1)'(num_reg);
    assign credit_time = (credit_sum > (pctm_pkg::NUM_W+1)'(pctm_pkg::TIME_MAX))
                         ? pctm_pkg::TIME_MAX : credit_sum[pctm_pkg::TIME_W-1:0];
    assign refund_val  = (num_reg > pctm_pkg::NUM_W'(pctm_pkg::REFUND_MAX))
                         ? pctm_pkg::REFUND_MAX : num_reg[pctm_pkg::REFUND_W-1:0];

    // Per-channel update during a walk
    always_comb
    begin
        walk_time = rd_time;
        walk_mode = pctm_pkg::MODE_VALUE;
        case (cmd_reg)
            pctm_pkg::CMD_MINUTE:
            begin
                walk_time = (rd_time > pctm_pkg::TICK_STEP) ? rd_time - pctm_pkg::TICK_STEP
                                                            : '0;
            end
            pctm_pkg::CMD_CLEAR_ALL:
            begin
                walk_time = '0;
            end
            pctm_pkg::CMD_DISPLAY:
            begin
                if (rd_time == '0)
                begin
                    walk_mode = flash_phase_reg ? pctm_pkg::MODE_BLANK : pctm_pkg::MODE_MARKER;
                end
            end
            default:
            begin
                walk_time = rd_time;
            end
        endcase
    end

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    case (req.command)
                        pctm_pkg::CMD_CREDIT,
                        pctm_pkg::CMD_REFUND:  state_next = ch_ok ? S_MUL1 : S_IDLE;
                        pctm_pkg::CMD_CLEAR:   state_next = ch_ok ? S_FIN : S_IDLE;
                        pctm_pkg::CMD_MINUTE,
                        pctm_pkg::CMD_CLEAR_ALL: state_next = S_WALK;
                        pctm_pkg::CMD_DISPLAY: state_next = factory_mode_reg ? S_IDLE : S_WALK;
                        default:               state_next = S_IDLE;
                    endcase
                end
            end
            S_MUL1: state_next = S_MUL2;
            S_MUL2: state_next = S_DIV;
            S_DIV:  state_next = (div_cnt_reg == DIV_LAST) ? S_FIN : S_DIV;
            S_FIN:  state_next = slot_free ? S_IDLE : S_FIN;
            S_WALK: state_next = (slot_free && walk_reg == CH_LAST) ? S_IDLE : S_WALK;
            default: state_next = S_IDLE;
        endcase
    end

    // Control registers, channel store and flash phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            walk_reg        <= '0;
            div_cnt_reg     <= '0;
            out_valid_reg   <= 1'b0;
            flash_phase_reg <= 1'b0;
            for (int i = 0; i < pctm_pkg::NUM_CHANNELS; i++)
            begin
                channel_time_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;

            // flash toggles on an accepted display tick outside factory mode
            if (req_fire && req.command == pctm_pkg::CMD_DISPLAY && !factory_mode_reg)
            begin
                flash_phase_reg <= !flash_phase_reg;
            end

            if (state_reg == S_IDLE)
            begin
                walk_reg    <= '0;
                div_cnt_reg <= '0;
            end
            else if (state_reg == S_DIV)
            begin
                div_cnt_reg <= div_cnt_reg + 1'b1;
            end
            else if (state_reg == S_WALK && slot_free)
            begin
                walk_reg <= walk_reg + 1'b1;
            end

            // store write, one address per cycle
            if (state_reg == S_FIN && slot_free)
            begin
                if (cmd_reg == pctm_pkg::CMD_CREDIT)
                begin
                    channel_time_reg[ch_reg] <= credit_time;
                end
                else if (cmd_reg == pctm_pkg::CMD_CLEAR)
                begin
                    channel_time_reg[ch_reg] <= '0;
                end
            end
            else if (state_reg == S_WALK && slot_free)
            begin
                channel_time_reg[walk_reg] <= walk_time;
            end

            // output valid
            if ((state_reg == S_FIN || state_reg == S_WALK) && slot_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Request latch and multiply/divide datapath
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            cmd_reg   <= req.command;
            ch_reg    <= req.channel;
            money_reg <= req.money_amount;
        end
        case (state_reg)
            S_MUL1:
            begin
                num_reg <= pctm_pkg::NUM_W'(mul_p);
            end
            S_MUL2:
            begin
                rem_reg <= '0;
                if (cmd_reg == pctm_pkg::CMD_CREDIT)
                begin
                    num_reg <= x10_out;
                    den_reg <= pctm_pkg::DEN_W'(money_rate_reg);
                end
                else
                begin
                    den_reg <= x10_out[pctm_pkg::DEN_W-1:0];
                end
            end
            S_DIV:
            begin
                num_reg <= {num_reg[pctm_pkg::NUM_W-2:0], q_bit};
                rem_reg <= q_bit ? rem_shift - pctm_pkg::REM_W'(den_reg) : rem_shift;
            end
            default:
            begin
                rem_reg <= rem_reg;
            end
        endcase
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (state_reg == S_FIN && slot_free)
        begin
            out_reg.out_channel   <= ch_reg;
            out_reg.display_mode  <= pctm_pkg::MODE_VALUE;
            out_reg.last          <= 1'b1;
            out_reg.refund_amount <= (cmd_reg == pctm_pkg::CMD_REFUND) ? refund_val : '0;
            case (cmd_reg)
                pctm_pkg::CMD_CREDIT:
                begin
                    out_reg.remaining_time <= credit_time;
                    out_reg.display_value  <= pctm_pkg::div10(credit_time);
                    out_reg.relay_on       <= credit_time != '0;
                end
                pctm_pkg::CMD_REFUND:
                begin
                    out_reg.remaining_time <= rd_time;
                    out_reg.display_value  <= pctm_pkg::div10(rd_time);
                    out_reg.relay_on       <= rd_time != '0;
                end
                default:
                begin
                    out_reg.remaining_time <= '0;
                    out_reg.display_value  <= '0;
                    out_reg.relay_on       <= 1'b0;
                end
            endcase
        end
        else if (state_reg == S_WALK && slot_free)
        begin
            out_reg.out_channel    <= walk_reg;
            out_reg.remaining_time <= walk_time;
            out_reg.display_value  <= (walk_mode == pctm_pkg::MODE_VALUE)
                                      ? pctm_pkg::div10(walk_time) : '0;
            out_reg.display_mode   <= walk_mode;
            out_reg.relay_on       <= walk_time != '0;
            out_reg.refund_amount  <= '0;
            out_reg.last           <= walk_reg == CH_LAST;
        end
    end

    assign req.ready          = state_reg == S_IDLE;
    assign rsp.valid          = out_valid_reg;
    assign rsp.out_channel    = out_reg.out_channel;
    assign rsp.remaining_time = out_reg.remaining_time;
    assign rsp.display_value  = out_reg.display_value;
    assign rsp.display_mode   = out_reg.display_mode;
    assign rsp.relay_on       = out_reg.relay_on;
    assign rsp.refund_amount  = out_reg.refund_amount;
    assign rsp.last           = out_reg.last;

    // APB configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_rate_reg    <= pctm_pkg::RATE_W'(1);
            money_rate_reg   <= pctm_pkg::RATE_W'(1);
            factory_mode_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                pctm_pkg::REG_TIME_RATE:    time_rate_reg    <= pwdata[pctm_pkg::RATE_W-1:0];
                pctm_pkg::REG_MONEY_RATE:   money_rate_reg   <= pwdata[pctm_pkg::RATE_W-1:0];
                pctm_pkg::REG_FACTORY_MODE: factory_mode_reg <= pwdata[0];
                default:                    factory_mode_reg <= factory_mode_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            pctm_pkg::REG_TIME_RATE:    prdata = 32'(time_rate_reg);
            pctm_pkg::REG_MONEY_RATE:   prdata = 32'(money_rate_reg);
            pctm_pkg::REG_FACTORY_MODE: prdata = 32'(factory_mode_reg);
            default:                    prdata = '0;
        endcase
    end

    // Assertions
    `ASSERT_NEXT(a_credit_starts_mul, req_fire && ch_ok && req.command == pctm_pkg::CMD_CREDIT, state_reg == S_MUL1, "credit request did not start the multiply")
    `ASSERT_IMPL(a_div_count, state_reg == S_DIV, div_cnt_reg <= DIV_LAST, "divider ran past its last step")
    `ASSERT_IMPL(a_time_max, rsp.valid, rsp.remaining_time <= pctm_pkg::TIME_MAX, "remaining time above saturation limit")
    `ASSERT_IMPL(a_refund_single, rsp.valid && rsp.refund_amount != '0, rsp.last && rsp.display_mode == pctm_pkg::MODE_VALUE, "refund on a walk result")
    `ASSERT_IMPL(a_flash_mode, rsp.valid && rsp.display_mode != pctm_pkg::MODE_VALUE, !rsp.relay_on && rsp.display_value == '0, "flash mode on a channel with time")

endmodule
